// ===== rtl/core/btag_pkg.sv =====
// Package for the broadcast tile address generator.
// Holds register indexes, field widths and the dimension and face helpers.
// No dependencies.
package btag_pkg;

    localparam int DEF_MAX_DIMS = 4;
    localparam int TILE_SIDE    = 32;
    localparam int FACE_SIDE    = 16;
    localparam int TILE_BITS    = $clog2(TILE_SIDE);
    localparam int FACE_BITS    = $clog2(FACE_SIDE);
    localparam int PACKED_DIMS  = 4;
    localparam int DIM_W        = 16;
    localparam int RANK_W       = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;

    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_RANK       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_RANK      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_SHAPE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SHAPE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BROADCAST_MAP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_TILE_GRID  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_TILE_GRID = 3'd6;

    function automatic logic [DIM_W-1:0] dim_size(input logic [63:0] shape_v,
                                                  input logic [RANK_W-1:0] d);
        logic [DIM_W-1:0] v;
        v = '0;
        for (int i = 0; i < PACKED_DIMS; i++) begin
            if (d == RANK_W'(i)) begin
                v = shape_v[i*DIM_W +: DIM_W];
            end
        end
        return v;
    endfunction

    function automatic logic [1:0] map_entry(input logic [7:0] map_v,
                                             input logic [RANK_W-1:0] d);
        logic [1:0] v;
        v = '0;
        for (int i = 0; i < PACKED_DIMS; i++) begin
            if (d == RANK_W'(i)) begin
                v = map_v[i*2 +: 2];
            end
        end
        return v;
    endfunction

    function automatic logic [9:0] face_index(input logic [TILE_BITS-1:0] r,
                                              input logic [TILE_BITS-1:0] c);
        return {r[FACE_BITS], c[FACE_BITS], r[FACE_BITS-1:0], c[FACE_BITS-1:0]};
    endfunction

endpackage

// ===== rtl/core/btag_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// A zero divisor gives quotient 0 and remainder equal to the dividend.
// Depends on nothing; the divisor must stay constant while items are in flight.
module btag_div_pipe #(
    parameter int W  = 32,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [W-1:0]  i_dividend,
    input  logic [W-1:0]  i_divisor,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [W-1:0]  o_quot,
    output logic [W-1:0]  o_rem,
    output logic [SW-1:0] o_side
);

    logic          r_v    [W];
    logic [W-1:0]  r_rem  [W];
    logic [W-1:0]  r_dvd  [W];
    logic [W-1:0]  r_q    [W];
    logic [SW-1:0] r_side [W];

    logic w_div_nz;
    assign w_div_nz = (i_divisor != '0);

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic          p_v;
        logic [W-1:0]  p_rem;
        logic [W-1:0]  p_dvd;
        logic [W-1:0]  p_q;
        logic [SW-1:0] p_side;
        logic [W:0]    trial;
        logic          take;

        if (k == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_rem  = '0;
            assign p_dvd  = i_dividend;
            assign p_q    = '0;
            assign p_side = i_side;
        end else begin : g_next
            assign p_v    = r_v[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_dvd  = r_dvd[k-1];
            assign p_q    = r_q[k-1];
            assign p_side = r_side[k-1];
        end

        assign trial = {p_rem, p_dvd[W-1]};
        assign take  = w_div_nz && (trial >= {1'b0, i_divisor});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= take ? W'(trial - {1'b0, i_divisor}) : trial[W-1:0];
                r_dvd[k]  <= p_dvd << 1;
                r_q[k]    <= {p_q[W-2:0], take};
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid = r_v[W-1];
    assign o_quot  = r_q[W-1];
    assign o_rem   = r_rem[W-1];
    assign o_side  = r_side[W-1];

endmodule

// ===== rtl/core/broadcast_tile_address_generator.sv =====
// Broadcast tile address generator, top level. Depends on btag_pkg and btag_div_pipe.
// Pipeline, NB = max(MAX_DIMS - 2, 1): input register, two 32-stage tile decode dividers,
// extent stage, a 32-stage divider per batch dimension, coordinate stage, a multiply stage per
// batch dimension, two tile number multiply stages, output register.
// Throughput: one beat per cycle; the whole pipeline holds while the output beat waits.
// Reset: synchronous, active low; clears all valid bits and loads the register defaults.
module broadcast_tile_address_generator #(
    parameter int MAX_DIMS = btag_pkg::DEF_MAX_DIMS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [btag_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [btag_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // out_tile_number[31:0], row_in_tile[36:32], col_in_tile[41:37], zero fill
    input  logic [btag_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // source_tile[31:0], source_offset[41:32], dest_offset[51:42], in_extent[52], zero fill
    output logic [btag_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);
    import btag_pkg::*;

    localparam int NB  = (MAX_DIMS > 2) ? MAX_DIMS - 2 : 1;
    localparam int RB  = 75;
    localparam int SBW = NB * 32 + RB;
    localparam logic [RANK_W-1:0] MAXR = RANK_W'(MAX_DIMS);

    logic [2:0]  r_input_rank;
    logic [2:0]  r_output_rank;
    logic [63:0] r_input_shape;
    logic [63:0] r_output_shape;
    logic [7:0]  r_broadcast_map;
    logic [63:0] r_input_tile_grid;
    logic [63:0] r_output_tile_grid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_rank       <= 3'd2;
            r_output_rank      <= 3'd2;
            r_input_shape      <= '0;
            r_output_shape     <= '0;
            r_broadcast_map    <= '0;
            r_input_tile_grid  <= '0;
            r_output_tile_grid <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_INPUT_RANK:       r_input_rank       <= i_cfg_data[2:0];
                CFG_OUTPUT_RANK:      r_output_rank      <= i_cfg_data[2:0];
                CFG_INPUT_SHAPE:      r_input_shape      <= i_cfg_data;
                CFG_OUTPUT_SHAPE:     r_output_shape     <= i_cfg_data;
                CFG_BROADCAST_MAP:    r_broadcast_map    <= i_cfg_data[7:0];
                CFG_INPUT_TILE_GRID:  r_input_tile_grid  <= i_cfg_data;
                CFG_OUTPUT_TILE_GRID: r_output_tile_grid <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    logic [RANK_W-1:0] w_irank;
    logic [RANK_W-1:0] w_orank;
    logic [31:0]       w_o_rows;
    logic [31:0]       w_o_per;
    logic [31:0]       w_i_rows;
    logic [31:0]       w_i_per;

    assign w_irank  = ({1'b0, r_input_rank} > MAXR) ? MAXR : {1'b0, r_input_rank};
    assign w_orank  = ({1'b0, r_output_rank} > MAXR) ? MAXR : {1'b0, r_output_rank};
    assign w_o_rows = r_output_tile_grid[63:32];
    assign w_o_per  = r_output_tile_grid[31:0];
    assign w_i_rows = r_input_tile_grid[63:32];
    assign w_i_per  = r_input_tile_grid[31:0];

    logic [31:0] r_mat;
    always_ff @(posedge i_clk) begin
        r_mat <= 32'(w_o_rows * w_o_per);
    end

    logic w_en;
    logic r_out_v;
    logic [OUT_DATA_W-1:0] r_out_data;

    assign w_en            = !r_out_v || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // Input register.
    logic        r_in_v;
    logic [31:0] r_in_tile;
    logic [4:0]  r_in_row;
    logic [4:0]  r_in_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (w_en) begin
            r_in_v <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_tile <= i_s_axis_tdata[31:0];
            r_in_row  <= i_s_axis_tdata[36:32];
            r_in_col  <= i_s_axis_tdata[41:37];
        end
    end

    // Tile number into batch and tile inside the matrix.
    logic        w_d1_v;
    logic [31:0] w_d1_q;
    logic [31:0] w_d1_r;
    logic [9:0]  w_d1_side;

    btag_div_pipe #(.W(32), .SW(10)) u_div_batch (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_in_v),
        .i_dividend (r_in_tile),
        .i_divisor  (r_mat),
        .i_side     ({r_in_row, r_in_col}),
        .o_valid    (w_d1_v),
        .o_quot     (w_d1_q),
        .o_rem      (w_d1_r),
        .o_side     (w_d1_side)
    );

    // Matrix tile into tile row and column.
    logic        w_d2_v;
    logic [31:0] w_d2_q;
    logic [31:0] w_d2_r;
    logic [41:0] w_d2_side;

    btag_div_pipe #(.W(32), .SW(42)) u_div_grid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (w_d1_v),
        .i_dividend (w_d1_r),
        .i_divisor  (w_o_per),
        .i_side     ({w_d1_q, w_d1_side}),
        .o_valid    (w_d2_v),
        .o_quot     (w_d2_q),
        .o_rem      (w_d2_r),
        .o_side     (w_d2_side)
    );

    // Element position and extent check.
    logic [4:0]  w_a_row;
    logic [4:0]  w_a_col;
    logic [31:0] w_a_row_base;
    logic [31:0] w_a_col_base;
    logic [31:0] w_a_row_size;
    logic [31:0] w_a_col_size;
    logic        w_a_row_ok;
    logic        w_a_col_ok;
    logic        w_a_inside;

    assign w_a_row      = w_d2_side[9:5];
    assign w_a_col      = w_d2_side[4:0];
    assign w_a_row_base = {w_d2_q[31-TILE_BITS:0], {TILE_BITS{1'b0}}};
    assign w_a_col_base = {w_d2_r[31-TILE_BITS:0], {TILE_BITS{1'b0}}};

    always_comb begin
        w_a_row_size = {16'b0, dim_size(r_output_shape, w_orank - RANK_W'(2))};
        if (w_orank == RANK_W'(1)) begin
            w_a_col_size = {16'b0, dim_size(r_output_shape, '0)};
        end else begin
            w_a_col_size = {16'b0, dim_size(r_output_shape, w_orank - RANK_W'(1))};
        end
        w_a_row_ok = (w_a_row_base < w_a_row_size)
                  && ({27'b0, w_a_row} < (w_a_row_size - w_a_row_base));
        w_a_col_ok = (w_a_col_base < w_a_col_size)
                  && ({27'b0, w_a_col} < (w_a_col_size - w_a_col_base));
        if (w_orank == '0) begin
            w_a_inside = (w_a_row == '0) && (w_a_col == '0);
        end else if (w_orank == RANK_W'(1)) begin
            w_a_inside = (w_a_row == '0) && w_a_col_ok;
        end else begin
            w_a_inside = w_a_row_ok && w_a_col_ok;
        end
    end

    logic           r_a_v;
    logic [31:0]    r_a_batch;
    logic [SBW-1:0] r_a_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= w_d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_batch <= w_d2_side[41:10];
            r_a_side  <= {{(NB*32){1'b0}}, 32'(w_a_row_base + {27'b0, w_a_row}),
                          32'(w_a_col_base + {27'b0, w_a_col}), w_a_inside,
                          w_a_row, w_a_col};
        end
    end

    // Batch index split into coordinates, innermost batch dimension first.
    logic           w_bv    [NB+1];
    logic [31:0]    w_bq    [NB+1];
    logic [SBW-1:0] w_bside [NB+1];

    assign w_bv[0]    = r_a_v;
    assign w_bq[0]    = r_a_batch;
    assign w_bside[0] = r_a_side;

    for (genvar k = 0; k < NB; k++) begin : g_batch
        logic           active;
        logic [31:0]    divisor;
        logic [31:0]    rem;
        logic [SBW-1:0] side;

        assign active  = (w_orank >= RANK_W'(k + 3));
        assign divisor = active
                       ? {16'b0, dim_size(r_output_shape, w_orank - RANK_W'(k + 3))}
                       : 32'd1;

        btag_div_pipe #(.W(32), .SW(SBW)) u_div_dim (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (w_en),
            .i_valid    (w_bv[k]),
            .i_dividend (w_bq[k]),
            .i_divisor  (divisor),
            .i_side     (w_bside[k]),
            .o_valid    (w_bv[k+1]),
            .o_quot     (w_bq[k+1]),
            .o_rem      (rem),
            .o_side     (side)
        );

        always_comb begin
            w_bside[k+1] = side;
            w_bside[k+1][RB + 32*k +: 32] = rem;
        end
    end

    // Coordinate stage: map every input dimension to its output coordinate.
    logic [SBW-1:0] w_cs;
    logic [31:0]    w_orow;
    logic [31:0]    w_ocol;
    logic [31:0]    w_base  [MAX_DIMS];
    logic [31:0]    w_coord [MAX_DIMS];
    logic [31:0]    w_irow;
    logic [31:0]    w_icol;

    assign w_cs   = w_bside[NB];
    assign w_orow = w_cs[74:43];
    assign w_ocol = w_cs[42:11];

    always_comb begin
        for (int m = 0; m < MAX_DIMS; m++) begin
            w_base[m] = '0;
            for (int j = 0; j < NB; j++) begin
                if ((w_orank >= RANK_W'(m + 3)) && (w_orank == RANK_W'(m + 3 + j))) begin
                    w_base[m] = w_cs[RB + 32*j +: 32];
                end
            end
        end
    end

    always_comb begin
        for (int d = 0; d < MAX_DIMS; d++) begin
            logic [RANK_W-1:0] od;
            od = {2'b0, map_entry(r_broadcast_map, RANK_W'(d))};
            w_coord[d] = '0;
            if (dim_size(r_input_shape, RANK_W'(d)) == DIM_W'(1)) begin
                w_coord[d] = '0;
            end else if (w_orank == '0) begin
                w_coord[d] = '0;
            end else if (w_orank == RANK_W'(1)) begin
                w_coord[d] = w_ocol;
            end else if (od == w_orank - RANK_W'(1)) begin
                w_coord[d] = w_ocol;
            end else if (od == w_orank - RANK_W'(2)) begin
                w_coord[d] = w_orow;
            end else begin
                for (int m = 0; m < MAX_DIMS; m++) begin
                    if (od == RANK_W'(m)) begin
                        w_coord[d] = w_base[m];
                    end
                end
            end
        end
    end

    always_comb begin
        w_irow = '0;
        w_icol = '0;
        if (w_irank == RANK_W'(1)) begin
            w_icol = w_coord[0];
        end else if (w_irank >= RANK_W'(2)) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
                if (w_irank == RANK_W'(d + 2)) begin
                    w_irow = w_coord[d];
                end
                if (w_irank == RANK_W'(d + 1)) begin
                    w_icol = w_coord[d];
                end
            end
        end
    end

    typedef struct packed {
        logic [NB-1:0][31:0] coord;
        logic [31:0]         ib;
        logic [31:0]         irow;
        logic [31:0]         icol;
        logic                in_ext;
        logic [4:0]          row;
        logic [4:0]          col;
    } t_mstage;

    logic    r_c_v;
    t_mstage r_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (w_en) begin
            r_c_v <= w_bv[NB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NB; k++) begin
                r_c.coord[k] <= w_coord[k];
            end
            r_c.ib     <= '0;
            r_c.irow   <= w_irow;
            r_c.icol   <= w_icol;
            r_c.in_ext <= w_cs[10];
            r_c.row    <= w_cs[9:5];
            r_c.col    <= w_cs[4:0];
        end
    end

    // Batch dimensions of the input folded into one batch index.
    logic    w_mv [NB+1];
    t_mstage w_m  [NB+1];

    assign w_mv[0] = r_c_v;
    assign w_m[0]  = r_c;

    for (genvar k = 0; k < NB; k++) begin : g_fold
        logic    r_v;
        t_mstage r_s;
        t_mstage n_s;

        always_comb begin
            n_s = w_m[k];
            if (w_irank >= RANK_W'(k + 3)) begin
                n_s.ib = 32'(w_m[k].ib * {16'b0, dim_size(r_input_shape, RANK_W'(k))})
                       + w_m[k].coord[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (w_en) begin
                r_v <= w_mv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_s <= n_s;
            end
        end

        assign w_mv[k+1] = r_v;
        assign w_m[k+1]  = r_s;
    end

    // Input tile number.
    logic        r_p1_v;
    logic        r_p2_v;
    logic [31:0] r_p1_t;
    logic [31:0] r_p2_t;
    t_mstage     r_p1;
    t_mstage     r_p2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
        end else if (w_en) begin
            r_p1_v <= w_mv[NB];
            r_p2_v <= r_p1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1   <= w_m[NB];
            r_p1_t <= 32'(w_m[NB].ib * w_i_rows) + (w_m[NB].irow >> TILE_BITS);
            r_p2   <= r_p1;
            r_p2_t <= 32'(r_p1_t * w_i_per) + (r_p1.icol >> TILE_BITS);
        end
    end

    logic [31:0] w_src_tile;
    logic [9:0]  w_src_off;

    always_comb begin
        if (w_irank >= RANK_W'(2)) begin
            w_src_tile = r_p2_t;
        end else if (w_irank == RANK_W'(1)) begin
            w_src_tile = r_p2.icol >> TILE_BITS;
        end else begin
            w_src_tile = '0;
        end
        w_src_off = face_index(r_p2.irow[TILE_BITS-1:0], r_p2.icol[TILE_BITS-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= r_p2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= {3'b0, r_p2.in_ext, face_index(r_p2.row, r_p2.col),
                           r_p2.in_ext ? w_src_off : 10'd0,
                           r_p2.in_ext ? w_src_tile : 32'd0};
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== rtl/core/btag_checker.sv =====
// Port-level assertions for the broadcast tile address generator.
// Depends on btag_pkg; bound to the top level at the end of this file.
module btag_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_cfg_we,
    input logic [btag_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input logic [btag_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic [btag_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [btag_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);

    // A stalled output beat stays in place with its data.
    a_out_hold: assert property (@(posedge i_clk)
        i_rst_n && o_m_axis_tvalid && !i_m_axis_tready
        |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output beat changed while stalled");

    // The input side is ready exactly when the output register can move.
    a_ready: assert property (@(posedge i_clk)
        i_rst_n |-> (o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready)))
        else $error("input ready does not follow output stall");

    // Padding beats carry a zero source tile and offset.
    a_pad_zero: assert property (@(posedge i_clk)
        o_m_axis_tvalid |-> (o_m_axis_tdata[52] || (o_m_axis_tdata[41:0] == 42'd0)))
        else $error("padding beat with nonzero source");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind broadcast_tile_address_generator btag_checker u_btag_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for broadcast_tile_address_generator.
// It drives element beats from a queue, predicts each tile mapping, and checks the result
// stream under random stalls. It depends on btag_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_top;
    import btag_pkg::*;

    typedef struct packed {
        logic [31:0] tile;
        logic [4:0]  row;
        logic [4:0]  col;
    } t_elem;

    typedef struct packed {
        logic [31:0] src_tile;
        logic [9:0]  src_off;
        logic [9:0]  dst_off;
        logic        in_ext;
    } t_tile_map;

    localparam int WATCHDOG_LIMIT = 5000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    broadcast_tile_address_generator i_dut (.*);

    logic [2:0]  m_in_rank, m_out_rank;
    logic [63:0] m_in_shape, m_out_shape, m_in_grid, m_out_grid;
    logic [7:0]  m_bmap;
    logic [31:0] batch_coord [4];

    t_elem     pending_elems[$];
    t_tile_map expected_maps[$];
    t_elem     cur_elem;

    int  n_errors, n_elems, n_maps, n_padding, n_phases;
    int  tx_gap, rx_gap, hold_left, idle_cycles;
    bit  tx_no_idle, rx_no_idle, hold_req, hold_taken;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic logic [31:0] dim_of(input logic [63:0] shape_v, input int d);
        if (d >= 4) return 32'd0;
        return {16'd0, shape_v[16*d +: 16]};
    endfunction

    function automatic logic [31:0] safe_div(input logic [31:0] a, input logic [31:0] b);
        return (b != 0) ? a / b : 32'd0;
    endfunction

    function automatic logic [31:0] safe_mod(input logic [31:0] a, input logic [31:0] b);
        return (b != 0) ? a % b : a;
    endfunction

    function automatic int clamp_rank(input logic [2:0] r);
        return (r > 3'd4) ? 4 : int'(r);
    endfunction

    function automatic logic [31:0] count_in_tile(input logic [31:0] size,
                                                  input logic [31:0] b);
        if (b >= size) return 32'd0;
        return (size - b < 32) ? size - b : 32'd32;
    endfunction

    function automatic logic [9:0] face_pos(input logic [31:0] r, input logic [31:0] c);
        logic [31:0] v;
        v = ((r / 16) * 2 + c / 16) * 256 + (r % 16) * 16 + (c % 16);
        return v[9:0];
    endfunction

    function automatic logic [31:0] out_dim_coord(input int orank, input int d,
                                                  input logic [31:0] orow,
                                                  input logic [31:0] ocol);
        if (orank == 0) return 32'd0;
        if (orank == 1) return ocol;
        if (d == orank - 1) return ocol;
        if (d == orank - 2) return orow;
        if (d >= 4) return 32'd0;
        return batch_coord[d];
    endfunction

    function automatic logic [31:0] in_dim_coord(input int orank, input int d,
                                                 input logic [31:0] orow,
                                                 input logic [31:0] ocol);
        int md;
        if (dim_of(m_in_shape, d) == 32'd1) return 32'd0;
        md = (d >= 4) ? 0 : int'(m_bmap[2*d +: 2]);
        return out_dim_coord(orank, md, orow, ocol);
    endfunction

    function automatic t_tile_map predict_mapping(input t_elem e);
        t_tile_map   res;
        int          irank, orank, d;
        logic [31:0] o_rows, o_per, i_rows, i_per, mat, batch, mtile;
        logic [31:0] row_base, col_base, orow, ocol, row_cnt, col_cnt, s;
        logic [31:0] ib, irow, icol, stile, srow, scol;
        logic        in_shape;
        irank = clamp_rank(m_in_rank);
        orank = clamp_rank(m_out_rank);
        o_rows = m_out_grid[63:32];
        o_per = m_out_grid[31:0];
        i_rows = m_in_grid[63:32];
        i_per = m_in_grid[31:0];
        mat = o_rows * o_per;
        batch = safe_div(e.tile, mat);
        mtile = safe_mod(e.tile, mat);
        row_base = safe_div(mtile, o_per) * 32;
        col_base = safe_mod(mtile, o_per) * 32;
        orow = row_base + e.row;
        ocol = col_base + e.col;
        row_cnt = 1;
        col_cnt = 1;
        if (orank == 1) begin
            col_cnt = count_in_tile(dim_of(m_out_shape, 0), col_base);
        end else if (orank >= 2) begin
            row_cnt = count_in_tile(dim_of(m_out_shape, orank - 2), row_base);
            col_cnt = count_in_tile(dim_of(m_out_shape, orank - 1), col_base);
        end
        in_shape = (e.row < row_cnt) && (e.col < col_cnt);
        for (int i = 0; i < 4; i++) batch_coord[i] = 32'd0;
        for (int i = 0; i < orank - 2; i++) begin
            d = orank - 3 - i;
            s = dim_of(m_out_shape, d);
            batch_coord[d] = safe_mod(batch, s);
            batch = safe_div(batch, s);
        end
        stile = 0;
        srow = 0;
        scol = 0;
        if (irank == 1) begin
            icol = in_dim_coord(orank, 0, orow, ocol);
            stile = icol / 32;
            scol = icol % 32;
        end else if (irank >= 2) begin
            ib = 0;
            for (d = 0; d < irank - 2; d++) begin
                ib = ib * dim_of(m_in_shape, d) + in_dim_coord(orank, d, orow, ocol);
            end
            irow = in_dim_coord(orank, irank - 2, orow, ocol);
            icol = in_dim_coord(orank, irank - 1, orow, ocol);
            stile = (ib * i_rows + irow / 32) * i_per + icol / 32;
            srow = irow % 32;
            scol = icol % 32;
        end
        res.src_tile = in_shape ? stile : 32'd0;
        res.src_off = in_shape ? face_pos(srow, scol) : 10'd0;
        res.dst_off = face_pos({27'd0, e.row}, {27'd0, e.col});
        res.in_ext = in_shape;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at beat %0d", what, got, want, n_maps);
        n_errors++;
    endtask

    // Sender side.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata <= '0;
            tx_gap <= 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_maps.push_back(predict_mapping(cur_elem));
                n_elems++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pending_elems.size() > 0) begin
                    cur_elem = pending_elems.pop_front();
                    i_s_axis_tdata <= {6'd0, cur_elem.col, cur_elem.row, cur_elem.tile};
                    i_s_axis_tvalid <= 1'b1;
                    tx_gap <= tx_no_idle ? 0 : $urandom_range(0, 9);
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver side.
    always @(posedge i_clk) begin
        t_tile_map got, want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            rx_gap <= 0;
            hold_left <= 0;
            hold_taken <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = {o_m_axis_tdata[31:0], o_m_axis_tdata[41:32], o_m_axis_tdata[51:42],
                       o_m_axis_tdata[52]};
                n_maps++;
                if (!got.in_ext) n_padding++;
                if (expected_maps.size() == 0) begin
                    report_mismatch("unexpected beat", got.src_tile, 32'd0);
                end else begin
                    want = expected_maps.pop_front();
                    if (got.src_tile !== want.src_tile)
                        report_mismatch("source_tile", got.src_tile, want.src_tile);
                    if (got.src_off !== want.src_off)
                        report_mismatch("source_offset", 32'(got.src_off),
                                        32'(want.src_off));
                    if (got.dst_off !== want.dst_off)
                        report_mismatch("dest_offset", 32'(got.dst_off),
                                        32'(want.dst_off));
                    if (got.in_ext !== want.in_ext)
                        report_mismatch("in_extent", 32'(got.in_ext), 32'(want.in_ext));
                end
            end
            if (hold_req && !hold_taken) begin
                hold_taken <= 1'b1;
                hold_left <= 400;
                i_m_axis_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_m_axis_tready <= 1'b0;
            end else if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (rx_no_idle) begin
                    i_m_axis_tready <= 1'b1;
                end else begin
                    rx_gap <= $urandom_range(0, 9);
                    i_m_axis_tready <= 1'b0;
                end
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) || i_cfg_we
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding.", expected_maps.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_INPUT_RANK:       m_in_rank = val[2:0];
            CFG_OUTPUT_RANK:      m_out_rank = val[2:0];
            CFG_INPUT_SHAPE:      m_in_shape = val;
            CFG_OUTPUT_SHAPE:     m_out_shape = val;
            CFG_BROADCAST_MAP:    m_bmap = val[7:0];
            CFG_INPUT_TILE_GRID:  m_in_grid = val;
            CFG_OUTPUT_TILE_GRID: m_out_grid = val;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [63:0] irank, input logic [63:0] orank,
                             input logic [63:0] ishape, input logic [63:0] oshape,
                             input logic [63:0] bmap, input logic [63:0] igrid,
                             input logic [63:0] ogrid);
        write_reg(CFG_INPUT_RANK, irank);
        write_reg(CFG_OUTPUT_RANK, orank);
        write_reg(CFG_INPUT_SHAPE, ishape);
        write_reg(CFG_OUTPUT_SHAPE, oshape);
        write_reg(CFG_BROADCAST_MAP, bmap);
        write_reg(CFG_INPUT_TILE_GRID, igrid);
        write_reg(CFG_OUTPUT_TILE_GRID, ogrid);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_phases++;
    endtask

    task automatic add_elem(input logic [31:0] tile, input logic [4:0] r, input logic [4:0] c);
        t_elem e;
        e.tile = tile;
        e.row = r;
        e.col = c;
        pending_elems.push_back(e);
    endtask

    task automatic add_random_elems(input int count);
        logic [31:0] span, t;
        span = m_out_grid[63:32] * m_out_grid[31:0];
        for (int i = 0; i < count; i++) begin
            if (span == 0 || span > 32'd4096 || $urandom_range(0, 9) == 0) begin
                t = $urandom;
            end else begin
                t = $urandom_range(0, 4 * span + 3);
            end
            add_elem(t, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
        end
    endtask

    task automatic drain;
        do @(posedge i_clk);
        while (pending_elems.size() != 0 || expected_maps.size() != 0 || i_s_axis_tvalid);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_dim;
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            default: return 16'($urandom_range(2, 80));
        endcase
    endfunction

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
        hold_req = 1'b0;
        m_in_rank = 3'd2;
        m_out_rank = 3'd2;
        m_in_shape = '0;
        m_out_shape = '0;
        m_bmap = '0;
        m_in_grid = '0;
        m_out_grid = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: zero shapes and grids exercise the divide-by-zero paths.
        add_elem(32'd0, 5'd0, 5'd0);
        add_elem(32'hFFFF_FFFF, 5'd31, 5'd31);
        add_elem(32'h5555_AAAA, 5'd16, 5'd15);
        add_random_elems(40);
        drain();

        // Plain 2-D broadcast of a row vector across 70x100.
        configure(64'd2, 64'd2, {32'd0, 16'd100, 16'd1}, {32'd0, 16'd100, 16'd70},
                  64'(8'b01_00), {32'd1, 32'd4}, {32'd3, 32'd4});
        add_elem(32'd0, 5'd0, 5'd0);
        add_elem(32'd11, 5'd31, 5'd31);
        add_elem(32'd3, 5'd5, 5'd3);
        add_elem(32'd3, 5'd4, 5'd4);
        add_elem(32'd8, 5'd6, 5'd0);
        add_elem(32'd8, 5'd5, 5'd31);
        add_elem(32'd12, 5'd0, 5'd0);
        tx_no_idle = 1'b1;
        rx_no_idle = 1'b1;
        add_random_elems(250);
        drain();

        // 4-D output with a 3-D input; the receiver holds off while the sender keeps going.
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
        configure(64'd3, 64'd4, {16'd0, 16'd50, 16'd1, 16'd3}, {16'd50, 16'd40, 16'd3, 16'd2},
                  64'(8'b00_11_10_01), {32'd1, 32'd2}, {32'd2, 32'd2});
        hold_req = 1'b1;
        add_random_elems(300);
        drain();

        // Rank 1 output and rank 0 input, then ranks that saturate, then rank 1 input and rank 0 output.
        configure(64'd0, 64'd1, 64'd0, {48'd0, 16'd45}, 64'd0, 64'd0, {32'd1, 32'd2});
        add_elem(32'd1, 5'd0, 5'd12);
        add_elem(32'd1, 5'd0, 5'd13);
        add_elem(32'd0, 5'd1, 5'd0);
        add_random_elems(100);
        drain();
        configure(64'd7, 64'd7, {16'd4, 16'd1, 16'd33, 16'd2}, {16'd33, 16'd2, 16'd4, 16'd3},
                  64'(8'hFF), {32'd2, 32'd2}, {32'd1, 32'd1});
        add_random_elems(100);
        drain();
        configure(64'd1, 64'd0, {48'd0, 16'd64}, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        add_elem(32'hFFFF_FFFF, 5'd0, 5'd0);
        add_elem(32'd0, 5'd31, 5'd31);
        add_random_elems(60);
        drain();

        // Random settings, each phase checked after the pipeline has emptied.
        for (int p = 0; p < 8; p++) begin
            tx_no_idle = ($urandom_range(0, 3) == 0);
            rx_no_idle = ($urandom_range(0, 3) == 0);
            configure(64'($urandom_range(0, 7)), 64'($urandom_range(0, 7)),
                      {rand_dim(), rand_dim(), rand_dim(), rand_dim()},
                      {rand_dim(), rand_dim(), rand_dim(), rand_dim()},
                      64'($urandom_range(0, 255)),
                      {32'($urandom_range(0, 4)), 32'($urandom_range(0, 4))},
                      {32'($urandom_range(0, 4)), 32'($urandom_range(0, 4))});
            add_random_elems(90);
            drain();
        end

        repeat (150) @(posedge i_clk);
        $display("Checked %0d element mappings over %0d register settings, %0d of them padding.",
                 n_maps, n_phases, n_padding);
        $display("Input beats: %0d, mismatches: %0d.", n_elems, n_errors);
        if (n_errors == 0 && expected_maps.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/btag_pkg.sv
rtl/core/btag_div_pipe.sv
rtl/core/broadcast_tile_address_generator.sv
rtl/core/btag_checker.sv
dv/tb_top.sv
